// ===== hw/rtl/nearest_channel_merge_defines.svh =====
// assertion macros for the channel merge block
`ifndef NEAREST_CHANNEL_MERGE_DEFINES_SVH
`define NEAREST_CHANNEL_MERGE_DEFINES_SVH

// implication checked every cycle outside reset
`define NCM_CHECK(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition that must never be true
`define NCM_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ===== hw/rtl/ncm_pkg.sv =====
// shared types and constants of the channel merge block
package ncm_pkg;

  localparam int NUM_SRC    = 4;
  localparam int NUM_LANES  = 2 * NUM_SRC;
  localparam int DIM_W      = 7;
  localparam int COORD_W    = 6;
  localparam int NUM_W      = DIM_W + COORD_W - 1;
  localparam int PLANE_BITS = 14;
  localparam logic [DIM_W-1:0] MAX_DIM = 7'd64;

  localparam logic [2:0] REG_DIMS0   = 3'd0;
  localparam logic [2:0] REG_DIMS1   = 3'd1;
  localparam logic [2:0] REG_DIMS2   = 3'd2;
  localparam logic [2:0] REG_DIMS3   = 3'd3;
  localparam logic [2:0] REG_CHANMAP = 3'd4;

  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  typedef struct packed {
    logic [NUM_SRC-1:0][13:0] dims;
    logic [7:0]               chan_map;
  } cfg_t;

  typedef struct packed {
    logic [NUM_LANES-1:0][NUM_W-1:0]   rem;
    logic [NUM_LANES-1:0][COORD_W-1:0] quo;
    logic [DIM_W-1:0]                  ow;
    logic [DIM_W-1:0]                  oh;
  } div_t;

  typedef struct packed {
    logic                              sample;
    logic                              err;
    logic [1:0]                        sel;
    logic [PLANE_BITS-1:0]             addr;
    logic [7:0]                        value;
    logic [NUM_SRC-1:0]                present;
    logic [NUM_SRC-1:0][DIM_W-1:0]     w;
    logic [NUM_SRC-1:0][1:0]           ch;
    div_t                              div;
  } pipe_t;

  typedef struct packed {
    logic                              sample;
    logic                              err;
    logic [NUM_SRC-1:0]                present;
    logic [NUM_SRC-1:0]                we;
    logic [NUM_SRC-1:0][PLANE_BITS-1:0] ram_addr;
    logic [7:0]                        value;
  } fetch_t;

  function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v);
    sat_dim = (v > MAX_DIM) ? MAX_DIM : v;
  endfunction

endpackage

// ===== hw/rtl/ncm_cfg.sv =====
// apb register file for source sizes and channel map
module ncm_cfg (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output ncm_pkg::cfg_t       cfg
);

  logic [2:0] idx;
  logic       wr;

  assign idx    = paddr[4:2];
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr) begin
      case (idx)
        ncm_pkg::REG_DIMS0:   cfg.dims[0]  <= pwdata[13:0];
        ncm_pkg::REG_DIMS1:   cfg.dims[1]  <= pwdata[13:0];
        ncm_pkg::REG_DIMS2:   cfg.dims[2]  <= pwdata[13:0];
        ncm_pkg::REG_DIMS3:   cfg.dims[3]  <= pwdata[13:0];
        ncm_pkg::REG_CHANMAP: cfg.chan_map <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      ncm_pkg::REG_DIMS0:   prdata = {18'd0, cfg.dims[0]};
      ncm_pkg::REG_DIMS1:   prdata = {18'd0, cfg.dims[1]};
      ncm_pkg::REG_DIMS2:   prdata = {18'd0, cfg.dims[2]};
      ncm_pkg::REG_DIMS3:   prdata = {18'd0, cfg.dims[3]};
      ncm_pkg::REG_CHANMAP: prdata = {24'd0, cfg.chan_map};
      default:              prdata = 32'd0;
    endcase
  end

endmodule

// ===== hw/rtl/ncm_div_stage.sv =====
// two restoring division steps for all eight coordinate lanes
module ncm_div_stage (
  input  logic                clk,
  input  logic                en,
  input  logic [2:0]          hi_bit,
  input  ncm_pkg::pipe_t      din,
  output ncm_pkg::pipe_t      dout
);

  ncm_pkg::pipe_t nxt;

  always_comb begin
    logic [ncm_pkg::NUM_W:0]   dsh;
    logic [ncm_pkg::DIM_W-1:0] d;
    logic [2:0]                b;
    nxt = din;
    for (int j = 0; j < ncm_pkg::NUM_LANES; j++) begin
      d = (j < ncm_pkg::NUM_SRC) ? din.div.ow : din.div.oh;
      for (int k = 0; k < 2; k++) begin
        b   = hi_bit - 3'(k);
        dsh = (ncm_pkg::NUM_W+1)'(d) << b;
        if ({1'b0, nxt.div.rem[j]} >= dsh) begin
          nxt.div.rem[j]    = nxt.div.rem[j] - dsh[ncm_pkg::NUM_W-1:0];
          nxt.div.quo[j][b] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= nxt;
    end
  end

endmodule

// ===== hw/rtl/ncm_plane_ram.sv =====
// one source plane, single port byte memory with registered read
module ncm_plane_ram (
  input  logic                              clk,
  input  logic                              en,
  input  logic                              we,
  input  logic [ncm_pkg::PLANE_BITS-1:0]    addr,
  input  logic [7:0]                        wdata,
  output logic [7:0]                        rdata
);

  logic [7:0] mem [2**ncm_pkg::PLANE_BITS];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end
      rdata <= mem[addr];
    end
  end

endmodule

// ===== hw/rtl/nearest_channel_merge.sv =====
// top level: nearest neighbor gather of four source planes into one rgba word
//
//   channel   direction  carries
//   s_*       in         load or sample word, mode in tuser
//   m_*       out        rgba word, coord_error in tuser
//   apb       in/out     source sizes and channel map
//
// six stages: size/multiply, three divider stages, address, memory read.
// one word per cycle while the output is not stalled; a sample result passes through every stage after accept.
// loads write in the memory stage, so they stay ordered with samples.
// synchronous reset clears valid bits and config registers; stage data and the store are not cleared.
// a stage holds on a stall only when it is full and the stage after it holds.
module nearest_channel_merge (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // source_sel[1:0] byte_addr[15:2] byte_value[23:16] out_x[29:24] out_y[35:30]
  input  logic [39:0]  s_tdata,
  // mode[0]
  input  logic [0:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // red[7:0] green[15:8] blue[23:16] alpha[31:24]
  output logic [31:0]  m_tdata,
  // coord_error[0]
  output logic [0:0]   m_tuser,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  ncm_pkg::cfg_t   cfg;
  ncm_pkg::pipe_t  a_next, a_q, b_q, c_q, d_q;
  ncm_pkg::fetch_t e_next, e_q, f_q;
  logic [5:0]      v;
  logic [5:0]      rdy;
  logic [ncm_pkg::NUM_SRC-1:0][7:0] rd;

  ncm_cfg u_cfg (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
  );

  // ready chain, a stage moves when it is empty or its successor moves
  assign rdy[5] = !v[5] || !f_q.sample || m_tready;
  assign rdy[4] = !v[4] || rdy[5];
  assign rdy[3] = !v[3] || rdy[4];
  assign rdy[2] = !v[2] || rdy[3];
  assign rdy[1] = !v[1] || rdy[2];
  assign rdy[0] = !v[0] || rdy[1];
  assign s_tready = rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) v[0] <= s_tvalid;
      if (rdy[1]) v[1] <= v[0];
      if (rdy[2]) v[2] <= v[1];
      if (rdy[3]) v[3] <= v[2];
      if (rdy[4]) v[4] <= v[3];
      if (rdy[5]) v[5] <= v[4];
    end
  end

  // output size, error flag and scaled numerators
  always_comb begin
    logic [ncm_pkg::DIM_W-1:0]   ow, oh, wi, hi;
    logic [ncm_pkg::COORD_W-1:0] x, y;
    logic                        any;
    ow  = '0;
    oh  = '0;
    any = 1'b0;
    x   = s_tdata[29:24];
    y   = s_tdata[35:30];
    a_next = '0;
    a_next.sample = (s_tuser[0] == ncm_pkg::MODE_SAMPLE);
    a_next.sel    = s_tdata[1:0];
    a_next.addr   = s_tdata[15:2];
    a_next.value  = s_tdata[23:16];
    for (int s = 0; s < ncm_pkg::NUM_SRC; s++) begin
      wi = ncm_pkg::sat_dim(cfg.dims[s][7:1]);
      hi = ncm_pkg::DIM_W'(cfg.dims[s][13:8]) + 7'd1;
      a_next.present[s] = cfg.dims[s][0];
      a_next.w[s]       = wi;
      a_next.ch[s]      = cfg.chan_map[2*s +: 2];
      if (cfg.dims[s][0]) begin
        any = 1'b1;
        if (wi > ow) ow = wi;
        if (hi > oh) oh = hi;
      end
      a_next.div.rem[s]                   = ncm_pkg::NUM_W'(x * wi);
      a_next.div.rem[s + ncm_pkg::NUM_SRC] = ncm_pkg::NUM_W'(y * hi);
    end
    a_next.div.ow = ow;
    a_next.div.oh = oh;
    a_next.err = !any || ({1'b0, x} >= ow) || ({1'b0, y} >= oh);
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) a_q <= a_next;
  end

  ncm_div_stage u_div0 (.clk(clk), .en(rdy[1]), .hi_bit(3'd5), .din(a_q), .dout(b_q));
  ncm_div_stage u_div1 (.clk(clk), .en(rdy[2]), .hi_bit(3'd3), .din(b_q), .dout(c_q));
  ncm_div_stage u_div2 (.clk(clk), .en(rdy[3]), .hi_bit(3'd1), .din(c_q), .dout(d_q));

  // plane addresses: for samples, pixel times four plus channel, wrapped to the plane; loads use their byte address
  always_comb begin
    logic [12:0] pix;
    e_next.sample  = d_q.sample;
    e_next.err     = d_q.err;
    e_next.present = d_q.present;
    e_next.value   = d_q.value;
    for (int s = 0; s < ncm_pkg::NUM_SRC; s++) begin
      pix = 13'(d_q.div.quo[s + ncm_pkg::NUM_SRC] * d_q.w[s]) + 13'(d_q.div.quo[s]);
      e_next.we[s] = !d_q.sample && (d_q.sel == 2'(s));
      e_next.ram_addr[s] = d_q.sample ? {pix[11:0], d_q.ch[s]} : d_q.addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[4]) e_q <= e_next;
    if (rdy[5]) f_q <= e_q;
  end

  for (genvar s = 0; s < ncm_pkg::NUM_SRC; s++) begin : g_plane
    ncm_plane_ram u_ram (
      .clk(clk), .en(rdy[5]), .we(v[4] && e_q.we[s]), .addr(e_q.ram_addr[s]),
      .wdata(e_q.value), .rdata(rd[s])
    );
  end

  always_comb begin
    for (int s = 0; s < ncm_pkg::NUM_SRC; s++) begin
      if (f_q.err) begin
        m_tdata[8*s +: 8] = 8'd0;
      end else if (f_q.present[s]) begin
        m_tdata[8*s +: 8] = rd[s];
      end else begin
        m_tdata[8*s +: 8] = (s == ncm_pkg::NUM_SRC - 1) ? 8'd255 : 8'd0;
      end
    end
  end

  assign m_tvalid   = v[5] && f_q.sample;
  assign m_tuser[0] = f_q.err;

`include "nearest_channel_merge_defines.svh"

  `NCM_CHECK(a_err_zero, (m_tvalid && m_tuser[0]) |-> (m_tdata == 32'd0), "error word not zero")
  `NCM_CHECK(a_accept_fills, (s_tvalid && s_tready) |=> v[0], "accepted word lost at entry")
  `NCM_NEVER(a_stall_full, !s_tready && !(v[0] && v[1] && v[2] && v[3] && v[4]), "stall with bubble")

endmodule

// ===== dv/tb_top.sv =====
// testbench of the nearest neighbor channel merge block
module tb_top;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  // source_sel[1:0] byte_addr[15:2] byte_value[23:16] out_x[29:24] out_y[35:30]
  logic [39:0] s_tdata = '0;
  // mode[0]
  logic [0:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // red[7:0] green[15:8] blue[23:16] alpha[31:24]
  logic [31:0] m_tdata;
  // coord_error[0]
  logic [0:0]  m_tuser;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  nearest_channel_merge uut (.*);

  always #10 clk = ~clk;

  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       coord_error;
  } pixel_t;

  // shadow copy of the store, registers and the written flags
  logic [7:0]  plane_mem [ncm_pkg::NUM_SRC][1<<ncm_pkg::PLANE_BITS];
  bit          plane_set [ncm_pkg::NUM_SRC][1<<ncm_pkg::PLANE_BITS];
  logic [13:0] dims_sh [ncm_pkg::NUM_SRC];
  logic [7:0]  chan_sh;
  pixel_t      pixel_q[$];
  int          n_fail = 0;
  int          n_sent = 0;
  bit          quiet = 1'b0;   // no idling on either side
  bit          hold_rx = 1'b0;

  function automatic int src_w(int s);
    int v;
    v = int'(dims_sh[s][7:1]);
    return v > 64 ? 64 : v;
  endfunction

  function automatic int src_h(int s);
    return int'(dims_sh[s][13:8]) + 1;
  endfunction

  function automatic int fetch_idx(int s, int x, int y, int ow, int oh);
    int sx, sy;
    sx = (x * src_w(s)) / ow;
    sy = (y * src_h(s)) / oh;
    return ((sy * src_w(s) + sx) * 4 + chan_sh[2*s +: 2]) & 16'h3fff;
  endfunction

  function automatic int out_w();
    int ow;
    ow = 0;
    for (int s = 0; s < ncm_pkg::NUM_SRC; s++)
      if (dims_sh[s][0] && src_w(s) > ow) ow = src_w(s);
    return ow;
  endfunction

  function automatic int out_h();
    int oh;
    oh = 0;
    for (int s = 0; s < ncm_pkg::NUM_SRC; s++)
      if (dims_sh[s][0] && src_h(s) > oh) oh = src_h(s);
    return oh;
  endfunction

  function automatic pixel_t gather_pixel(int x, int y);
    pixel_t p;
    int ow, oh;
    logic [7:0] b [ncm_pkg::NUM_SRC];
    ow = out_w();
    oh = out_h();
    p = '0;
    if (x >= ow || y >= oh) begin
      p.coord_error = 1'b1;
      return p;
    end
    for (int s = 0; s < ncm_pkg::NUM_SRC; s++) begin
      if (!dims_sh[s][0]) b[s] = (s == 3) ? 8'hff : 8'h00;
      else b[s] = plane_mem[s][fetch_idx(s, x, y, ow, oh)];
    end
    p.red = b[0];
    p.green = b[1];
    p.blue = b[2];
    p.alpha = b[3];
    return p;
  endfunction

  // a sample is legal only if every present source fetches a written byte; out of range samples are always legal
  function automatic bit sample_safe(int x, int y);
    int ow, oh;
    ow = out_w();
    oh = out_h();
    if (x >= ow || y >= oh) return 1'b1;
    for (int s = 0; s < ncm_pkg::NUM_SRC; s++)
      if (dims_sh[s][0] && !plane_set[s][fetch_idx(s, x, y, ow, oh)]) return 1'b0;
    return 1'b1;
  endfunction

  // starts and ends at a falling edge; tvalid stays up for a following word
  task automatic send_word(logic mode, logic [1:0] sel, logic [13:0] addr,
                           logic [7:0] val, logic [5:0] x, logic [5:0] y);
    while (!quiet && $urandom_range(99) < 14) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= mode;
    s_tdata <= {4'b0, y, x, val, addr, sel};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    n_sent++;
    if (mode == ncm_pkg::MODE_LOAD) begin
      plane_mem[sel][addr] = val;
      plane_set[sel][addr] = 1'b1;
    end else begin
      pixel_q.insert(pixel_q.size(), gather_pixel(x, y));
    end
    @(negedge clk);
  endtask

  task automatic load_byte(int s, int a, logic [7:0] v);
    send_word(ncm_pkg::MODE_LOAD, s[1:0], a[13:0], v, 6'($urandom), 6'($urandom));
  endtask

  task automatic sample_at(int x, int y);
    if (sample_safe(x, y))
      send_word(ncm_pkg::MODE_SAMPLE, 2'($urandom), 14'($urandom), 8'($urandom),
                x[5:0], y[5:0]);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    s_tvalid <= 1'b0;
    while (pixel_q.size() != 0 && guard < 100000) begin
      @(negedge clk);
      guard++;
    end
    repeat (12) @(negedge clk);
  endtask

  // psel stays up between writes, set_sizes drops it after the last one
  task automatic reg_write(logic [2:0] idx, logic [31:0] v);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    if (idx == ncm_pkg::REG_CHANMAP) chan_sh = v[7:0];
    else dims_sh[idx] = v[13:0];
  endtask

  task automatic set_sizes(logic [13:0] d0, logic [13:0] d1, logic [13:0] d2,
                           logic [13:0] d3, logic [7:0] cm);
    drain();
    reg_write(ncm_pkg::REG_DIMS0, 32'(d0));
    reg_write(ncm_pkg::REG_DIMS1, 32'(d1));
    reg_write(ncm_pkg::REG_DIMS2, 32'(d2));
    reg_write(ncm_pkg::REG_DIMS3, 32'(d3));
    reg_write(ncm_pkg::REG_CHANMAP, 32'(cm));
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // fill every byte a source of the given size can reach
  task automatic fill_source(int s);
    int n;
    n = src_w(s) * src_h(s) * 4;
    if (n == 0) n = 4;
    for (int a = 0; a < n; a++) load_byte(s, a, 8'($urandom));
  endtask

  task automatic test_directed();
    set_sizes(14'h0000, 14'h0000, 14'h0000, 14'h0000, 8'h00);
    sample_at(0, 0);
    sample_at(63, 63);
    // red 2x1, green of width zero, blue and alpha absent
    set_sizes({6'd0, 7'd2, 1'b1}, {6'd1, 7'd0, 1'b1}, 14'h0000, 14'h0000, 8'hff);
    load_byte(0, 16383, 8'hff);
    fill_source(0);
    fill_source(1);
    load_byte(1, 0, 8'h00);
    load_byte(1, 3, 8'h80);
    sample_at(0, 0);
    sample_at(1, 0);
    sample_at(1, 1);
    sample_at(2, 0);
    sample_at(0, 2);
    sample_at(63, 63);
    sample_at(0, 1);
  endtask

  // counts only words that were actually sent
  task automatic test_random(int n_items);
    int x, y, s, a, start;
    start = n_sent;
    while (n_sent - start < n_items) begin
      if ($urandom_range(3) == 0) begin
        s = $urandom_range(3);
        a = $urandom_range(16383);
        load_byte(s, a, 8'($urandom));
      end else begin
        x = $urandom_range(3) == 0 ? $urandom_range(63) : $urandom_range(out_w());
        y = $urandom_range(3) == 0 ? $urandom_range(63) : $urandom_range(out_h());
        sample_at(x, y);
      end
    end
  endtask

  task automatic test_phase(int n_items, bit saturate);
    logic [13:0] d [ncm_pkg::NUM_SRC];
    for (int s = 0; s < ncm_pkg::NUM_SRC; s++) begin
      d[s] = {$urandom_range(7) == 0 ? 6'd63 : 6'($urandom_range(7)),
              $urandom_range(4) == 0 ? 7'($urandom_range(127)) : 7'($urandom_range(8)),
              1'($urandom_range(3) != 0)};
      // oversized width on every source, only red present, one row high
      if (saturate) d[s] = {6'd0, 7'd127, 1'(s == 0)};
    end
    set_sizes(d[0], d[1], d[2], d[3], 8'($urandom));
    for (int s = 0; s < ncm_pkg::NUM_SRC; s++)
      if (dims_sh[s][0] && (saturate || src_w(s) * src_h(s) <= 32)) fill_source(s);
    test_random(n_items);
  endtask

  task automatic test_backpressure();
    set_sizes({6'd3, 7'd4, 1'b1}, {6'd0, 7'd1, 1'b1}, 14'h0, {6'd1, 7'd2, 1'b1}, 8'h1b);
    fill_source(0);
    fill_source(1);
    fill_source(3);
    quiet = 1'b1;
    hold_rx = 1'b1;
    for (int i = 0; i < 40; i++) sample_at($urandom_range(4), $urandom_range(4));
    hold_rx = 1'b0;
    test_random(150);
    quiet = 1'b0;
  endtask

  // receiver stalls
  always @(negedge clk) begin
    if (hold_rx || (!quiet && $urandom_range(99) < 14)) m_tready <= 1'b0;
    else m_tready <= 1'b1;
  end

  // long receiver hold-off, counted here while the sender keeps offering
  initial begin
    wait (hold_rx);
    repeat (200) @(negedge clk);
    hold_rx = 1'b0;
  end

  always @(posedge clk) begin
    pixel_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pixel_q.size() == 0) begin
        $error("result word with no sample pending");
        n_fail++;
      end else begin
        want = pixel_q.pop_front();
        if (m_tdata[7:0] !== want.red) begin
          $error("red: expected %0d, got %0d", want.red, m_tdata[7:0]); n_fail++;
        end
        if (m_tdata[15:8] !== want.green) begin
          $error("green: expected %0d, got %0d", want.green, m_tdata[15:8]); n_fail++;
        end
        if (m_tdata[23:16] !== want.blue) begin
          $error("blue: expected %0d, got %0d", want.blue, m_tdata[23:16]); n_fail++;
        end
        if (m_tdata[31:24] !== want.alpha) begin
          $error("alpha: expected %0d, got %0d", want.alpha, m_tdata[31:24]); n_fail++;
        end
        if (m_tuser[0] !== want.coord_error) begin
          $error("coord_error: expected %0d, got %0d", want.coord_error, m_tuser[0]);
          n_fail++;
        end
      end
    end
  end

  initial begin
    #40000000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    for (int s = 0; s < ncm_pkg::NUM_SRC; s++) dims_sh[s] = '0;
    chan_sh = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_backpressure();
    test_phase(100, 1'b1);
    for (int p = 0; p < 5; p++) test_phase(180, 1'b0);
    drain();
    if (pixel_q.size() != 0) n_fail++;
    if (n_fail == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule
